@@ rtl/double_hash_table_engine_core_defines.svh @@
// ----------------------------------------------------------------------------
// double hash table engine assertion macros
// shared property wrappers, clocked on i_clk and masked during reset
// ----------------------------------------------------------------------------
`ifndef DOUBLE_HASH_TABLE_ENGINE_CORE_DEFINES_SVH
`define DOUBLE_HASH_TABLE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication
`define DHTE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DHTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dhte_pkg.sv @@
// ----------------------------------------------------------------------------
// dhte_pkg
// widths, codes and types shared by the double hash table engine
// ----------------------------------------------------------------------------
`default_nettype none

package dhte_pkg;

    localparam int KEY_W    = 31;
    localparam int PAY_W    = 16;
    localparam int CFG_W    = 7;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FRAC_W   = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // golden-ratio fraction in 0.32 fixed point
    localparam logic [FRAC_W-1:0] GOLDEN_FRAC    = 32'h9E3779B9;
    localparam logic [CFG_W-1:0]  TABLE_SIZE_RST = 7'd64;

    // register word index (paddr[2])
    localparam logic [0:0] REG_TABLE_SIZE = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_DONE      = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_DUPLICATE = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic             occ;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/double_hash_table_engine_core.sv @@
// ----------------------------------------------------------------------------
// double_hash_table_engine_core
// open-addressed key/value table with double hashing, one command at a time
// ----------------------------------------------------------------------------
// A command (search, insert or remove of a key) is taken when start is high
// and busy is low. The result comes back as one word on the o_ ports,
// marked by o_done for exactly one cycle; the receiver cannot stall it, so
// it must take the word in that cycle. A command runs the bit-serial key
// mod m, m being the slots in use, then one probe per cycle through the single
// read port of the slot memory (registered read), then a finish state that
// writes back and registers the result. After reset the engine sweeps the slot
// memory once to clear the occupied marks, with busy high; configuration
// writes are taken during the sweep. table_size sits at byte address 0 of the
// APB port and may only change while busy is low; 0 acts as 1 and values
// above TABLE_DEPTH act as TABLE_DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_hash_table_engine_core_defines.svh"

module double_hash_table_engine_core
    import dhte_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [CMD_W-1:0]                  i_command,
    input  wire logic [KEY_W-1:0]                  i_key,
    input  wire logic [PAY_W-1:0]                  i_payload,
    // result word
    output logic                                   o_done,
    output logic [STATUS_W-1:0]                    o_status,
    output logic                                   o_hit,
    output logic [$clog2(TABLE_DEPTH)-1:0]         o_slot_index,
    output logic                                   o_slot_index_valid,
    output logic [PAY_W-1:0]                       o_payload_out,
    // configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [APB_AW-1:0]                 paddr,
    input  wire logic [APB_DW-1:0]                 pwdata,
    output logic [APB_DW-1:0]                      prdata,
    output logic                                   pready
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int M_W    = $clog2(TABLE_DEPTH + 1);
    localparam int SZ_W   = (CFG_W > M_W) ? CFG_W : M_W;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_table_size;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TABLE_SIZE) ? APB_DW'(r_table_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else if (cfg_wr && paddr[2] == REG_TABLE_SIZE) begin
            r_table_size <= pwdata[CFG_W-1:0];
        end
    end

    // slots in use, clamped to 1..TABLE_DEPTH
    logic [SZ_W-1:0] ts_ext;
    logic [M_W-1:0]  m;

    always_comb begin
        ts_ext = SZ_W'(r_table_size);
        if (ts_ext == '0) begin
            m = M_W'(1);
        end else if (ts_ext > SZ_W'(TABLE_DEPTH)) begin
            m = M_W'(TABLE_DEPTH);
        end else begin
            m = ts_ext[M_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // command registers and hash setup
    // ------------------------------------------------------------------
    t_state r_state, n_state;

    logic              accept;
    logic [CMD_W-1:0]  r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [PAY_W-1:0]  r_pay;
    logic [FRAC_W-1:0] r_frac;
    logic [FRAC_W-1:0] frac_c;
    logic [M_W+FRAC_W-1:0] step_prod;
    logic [ADDR_W-1:0] r_step;

    assign accept = start && !busy;

    // low word of key times the golden fraction
    assign frac_c    = FRAC_W'(i_key) * GOLDEN_FRAC;
    // step = floor(m * frac / 2^32), always below m
    assign step_prod = (M_W + FRAC_W)'(m) * (M_W + FRAC_W)'(r_frac);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_key  <= i_key;
            r_pay  <= i_payload;
            r_frac <= frac_c;
        end
        if (r_state == S_MOD) begin
            r_step <= step_prod[ADDR_W+FRAC_W-1:FRAC_W];
        end
    end

    // home slot = key mod m
    logic [M_W-1:0] mod_rem;
    logic           mod_done;

    dhte_mod_unit #(
        .DIV_W (M_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (i_key),
        .i_divisor  (m),
        .o_rem      (mod_rem),
        .o_done     (mod_done)
    );

    // ------------------------------------------------------------------
    // slot memory: occupied mark, key and payload per slot
    // ------------------------------------------------------------------
    t_entry            r_mem [TABLE_DEPTH];
    t_entry            r_rdata;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_entry            wr_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // probe walk: issue one read per cycle, check the word read last cycle
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_addr;
    logic [M_W-1:0]    r_issue_cnt;
    logic              r_chk_valid;
    logic [ADDR_W-1:0] r_chk_addr;
    logic              r_found;
    logic [ADDR_W-1:0] r_match;
    logic [PAY_W-1:0]  r_pay_hit;
    logic              r_have_free;
    logic [ADDR_W-1:0] r_free;

    logic              issue;
    logic              hit_c;
    logic              finish_c;
    logic              clr_last;
    logic [ADDR_W:0]   addr_sum;
    logic [ADDR_W-1:0] addr_next;

    assign clr_last = (r_clr_addr == ADDR_W'(TABLE_DEPTH - 1));
    assign issue    = (r_state == S_PROBE) && (r_issue_cnt != m);
    assign hit_c    = r_chk_valid && r_rdata.occ && (r_rdata.key == r_key);
    // the walk ends on a match or once the last issued slot has been checked
    assign finish_c = r_chk_valid && (hit_c || r_issue_cnt == m);

    // addr and step are both below m, so one subtract wraps the sum
    always_comb begin
        addr_sum = {1'b0, r_addr} + {1'b0, r_step};
        if (addr_sum >= (ADDR_W + 1)'(m)) begin
            addr_sum = addr_sum - (ADDR_W + 1)'(m);
        end
        addr_next = addr_sum[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_issue_cnt <= '0;
            r_chk_valid <= 1'b0;
            r_found     <= 1'b0;
            r_have_free <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (mod_done) begin
                r_addr      <= mod_rem[ADDR_W-1:0];
                r_issue_cnt <= '0;
                r_chk_valid <= 1'b0;
                r_found     <= 1'b0;
                r_have_free <= 1'b0;
            end else if (r_state == S_PROBE) begin
                r_chk_valid <= issue && !finish_c;
                if (issue) begin
                    r_chk_addr  <= r_addr;
                    r_addr      <= addr_next;
                    r_issue_cnt <= r_issue_cnt + 1'b1;
                end
                if (hit_c) begin
                    r_found   <= 1'b1;
                    r_match   <= r_chk_addr;
                    r_pay_hit <= r_rdata.payload;
                end else if (r_chk_valid && !r_rdata.occ && !r_have_free) begin
                    r_have_free <= 1'b1;
                    r_free      <= r_chk_addr;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_MOD;
            end
            S_MOD: begin
                if (mod_done) n_state = S_PROBE;
            end
            S_PROBE: begin
                if (finish_c) n_state = S_FINISH;
            end
            S_FINISH: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    logic do_insert;
    logic do_remove;

    assign do_insert = (r_cmd == CMD_INSERT) && !r_found && r_have_free;
    assign do_remove = (r_cmd == CMD_REMOVE) && r_found;

    always_comb begin
        busy    = 1'b1;
        rd_en   = 1'b0;
        rd_addr = r_addr;
        wr_en   = 1'b0;
        wr_addr = r_clr_addr;
        wr_data = '0;
        case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                busy = 1'b0;
            end
            S_PROBE: begin
                rd_en = issue;
            end
            S_FINISH: begin
                if (do_insert) begin
                    wr_en   = 1'b1;
                    wr_addr = r_free;
                    wr_data = '{occ: 1'b1, key: r_key, payload: r_pay};
                end else if (do_remove) begin
                    wr_en   = 1'b1;
                    wr_addr = r_match;
                    wr_data = '{occ: 1'b0, key: r_key, payload: r_pay_hit};
                end
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // result word
    // ------------------------------------------------------------------
    logic [STATUS_W-1:0] status_c;
    logic                r_done;
    logic [STATUS_W-1:0] r_status;
    logic                r_hit;
    logic [ADDR_W-1:0]   r_slot_index;
    logic                r_slot_valid;
    logic [PAY_W-1:0]    r_payload_out;

    always_comb begin
        case (r_cmd)
            CMD_INSERT: begin
                if (r_found) begin
                    status_c = STS_DUPLICATE;
                end else if (!r_have_free) begin
                    status_c = STS_FULL;
                end else begin
                    status_c = STS_DONE;
                end
            end
            default: begin
                // search, remove and the unused code
                status_c = r_found ? STS_DONE : STS_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == S_FINISH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH) begin
            r_status      <= status_c;
            r_hit         <= r_found;
            r_slot_valid  <= r_found || r_have_free;
            r_payload_out <= r_found ? r_pay_hit : '0;
            if (r_found) begin
                r_slot_index <= r_match;
            end else if (r_have_free) begin
                r_slot_index <= r_free;
            end else begin
                r_slot_index <= '0;
            end
        end
    end

    assign o_done             = r_done;
    assign o_status           = r_status;
    assign o_hit              = r_hit;
    assign o_slot_index       = r_slot_index;
    assign o_slot_index_valid = r_slot_valid;
    assign o_payload_out      = r_payload_out;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `DHTE_ASSERT_NEXT(a_finish_posts, r_state == S_FINISH, o_done && !busy, "result not posted after finish")
    `DHTE_ASSERT_SAME(a_probe_in_range, r_state == S_PROBE && r_chk_valid, (M_W + 1)'(r_chk_addr) < (M_W + 1)'(m), "probe slot beyond table size")
    `DHTE_ASSERT_SAME(a_hit_has_slot, o_done && o_hit, o_slot_index_valid, "hit without a valid slot")
    `DHTE_ASSERT_SAME(a_mod_in_setup, mod_done, r_state == S_MOD, "remainder done outside hash setup")

endmodule

`default_nettype wire

@@ rtl/dhte_mod_unit.sv @@
// ----------------------------------------------------------------------------
// dhte_mod_unit
// restoring remainder unit, one key bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dhte_mod_unit
    import dhte_pkg::*;
#(
    parameter int DIV_W = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KEY_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0] i_divisor,
    output logic      [DIV_W-1:0] o_rem,
    output logic                  o_done
);

    localparam int CNT_W = $clog2(KEY_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_num;
    logic [DIV_W-1:0] r_rem;

    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic [DIV_W-1:0] n_rem;

    // partial remainder stays below the divisor, so trial is below twice it
    always_comb begin
        trial = {r_rem, r_num[KEY_W-1]};
        diff  = trial - {1'b0, i_divisor};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = diff[DIV_W-1:0];
        end else begin
            n_rem = trial[DIV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(KEY_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= n_rem;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

`default_nettype wire
